/* sv/sorted_insert_priority_queue_unit_defines.svh */
// ----------------------------------------------------------------------------
// sorted insert priority queue unit defines
// assertion macros used by the queue rtl
// ----------------------------------------------------------------------------
`ifndef SORTED_INSERT_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// a condition that holds at every clock edge out of reset
`define SPQ_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// a condition that implies another at the next clock edge
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg
// shared constants, codes and types of the sorted insert priority queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int MODE_W      = 2;
  localparam int KEY_W       = 32;
  localparam int PAY_W       = 32;
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 5;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SORTED = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic        [PAY_W-1:0] payload;
  } entry_t;

  // per cell control for one operation
  typedef struct packed {
    logic insert;   // insert going ahead this cycle
    logic sorted;   // insert by key rather than at the rear
    logic remove;   // front removal going ahead this cycle
    logic occ;      // cell holds an entry
    logic tail;     // cell is the first free slot
  } cell_ctl_t;

endpackage

`default_nettype wire

/* sv/spq_in_if.sv */
// ----------------------------------------------------------------------------
// spq_in_if
// request channel of the priority queue: valid, ready and one operation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface spq_in_if
  import spq_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic signed [KEY_W-1:0]   item_key;
  logic [PAY_W-1:0]          item_payload;

  modport source (output valid, output mode, output item_key, output item_payload,
                  input ready);
  modport sink   (input valid, input mode, input item_key, input item_payload,
                  output ready);
endinterface

`default_nettype wire

/* sv/spq_out_if.sv */
// ----------------------------------------------------------------------------
// spq_out_if
// result channel of the priority queue: valid, ready and one result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface spq_out_if
  import spq_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic signed [KEY_W-1:0]   removed_key;
  logic [PAY_W-1:0]          removed_payload;
  logic [OCC_W-1:0]          occupancy;

  modport source (output valid, output status, output removed_key,
                  output removed_payload, output occupancy, input ready);
  modport sink   (input valid, input status, input removed_key,
                  input removed_payload, input occupancy, output ready);
endinterface

`default_nettype wire

/* sv/spq_cell.sv */
// ----------------------------------------------------------------------------
// spq_cell
// one queue slot: compares against the new key and shifts with its neighbors
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire entry_t    new_ent,
  input  wire entry_t    left_ent,
  input  wire entry_t    right_ent,
  input  wire logic      shift_in,
  output logic           shift_out,
  output entry_t         ent
);

  entry_t ent_r;
  entry_t ent_nxt;
  logic   mark;

  // first stored key strictly above the new one marks the insert point
  assign mark      = ctl.insert && ctl.sorted && ctl.occ && (ent_r.key > new_ent.key);
  assign shift_out = shift_in || mark;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.insert) begin
      if (shift_in) begin
        ent_nxt = left_ent;
      end else if (mark || ctl.tail) begin
        ent_nxt = new_ent;
      end
    end else if (ctl.remove) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;

endmodule

`default_nettype wire

/* sv/sorted_insert_priority_queue_unit.sv */
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_unit
// bounded key/payload queue with append, sorted insert and front removal
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_chan   in   valid / ready      mode, item_key, item_payload
//  out_chan  out  valid / ready      status, removed_key, removed_payload,
//                                    occupancy
//
//  one request per cycle while results are taken; the result is registered in
//  the cycle after acceptance, as the cell row compares and shifts every slot
//  synchronous active-low reset empties the queue and drops any pending result
//  a stalled result is held in the output register; a new request is taken
//  in the same cycle that the held result leaves
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_insert_priority_queue_unit_defines.svh"

module sorted_insert_priority_queue_unit
  import spq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  spq_in_if.sink     in_chan,
  spq_out_if.source  out_chan
);

  // occupancy and result register
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  logic                    out_valid_r;
  logic [STATUS_W-1:0]     status_r;
  logic [STATUS_W-1:0]     status_nxt;
  logic signed [KEY_W-1:0] rkey_r;
  logic signed [KEY_W-1:0] rkey_nxt;
  logic [PAY_W-1:0]        rpay_r;
  logic [PAY_W-1:0]        rpay_nxt;

  logic      accept;
  logic      is_insert;
  logic      is_remove;
  logic      full;
  logic      empty;
  logic      do_insert;
  logic      do_remove;
  logic      ins_full;
  logic      rm_empty;
  entry_t    new_ent;

  entry_t    ent   [QUEUE_DEPTH];
  logic      shift [QUEUE_DEPTH+1];

  // output register frees up when its result is taken
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  assign is_insert = in_chan.mode inside {MODE_APPEND, MODE_SORTED};
  assign is_remove = (in_chan.mode == MODE_REMOVE);
  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign do_insert = accept && is_insert && !full;
  assign do_remove = accept && is_remove && !empty;

  assign new_ent.key     = in_chan.item_key;
  assign new_ent.payload = in_chan.item_payload;

  // nothing lies ahead of the front cell
  assign shift[0] = 1'b0;

  // row of cells, slot 0 at the front
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    left_ent;
    entry_t    right_ent;

    assign ctl.insert = do_insert;
    assign ctl.sorted = (in_chan.mode == MODE_SORTED);
    assign ctl.remove = do_remove;
    assign ctl.occ    = (CNT_W'(i) < count_r);
    assign ctl.tail   = (CNT_W'(i) == count_r);

    if (i == 0) begin : g_front
      assign left_ent = new_ent;
    end else begin : g_mid_l
      assign left_ent = ent[i-1];
    end

    // the rear cell shifts in nothing on removal; that slot falls out of range
    if (i == QUEUE_DEPTH - 1) begin : g_rear
      assign right_ent = '0;
    end else begin : g_mid_r
      assign right_ent = ent[i+1];
    end

    spq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_ent   (new_ent),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .shift_in  (shift[i]),
      .shift_out (shift[i+1]),
      .ent       (ent[i])
    );
  end

  // result of the accepted request
  always_comb begin
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    rkey_nxt   = '0;
    rpay_nxt   = '0;
    if (is_insert) begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else if (is_remove) begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        count_nxt = count_r - CNT_W'(1);
        rkey_nxt  = ent[0].key;
        rpay_nxt  = ent[0].payload;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload side of the result register
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      rkey_r   <= rkey_nxt;
      rpay_r   <= rpay_nxt;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.status          = status_r;
  assign out_chan.removed_key     = rkey_r;
  assign out_chan.removed_payload = rpay_r;
  assign out_chan.occupancy       = OCC_W'(count_r);

  // refused requests
  assign ins_full = accept && is_insert && full;
  assign rm_empty = accept && is_remove && empty;

  // checks
  `SPQ_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(QUEUE_DEPTH), "count above depth")
  `SPQ_ASSERT_NEXT(a_occ_follows, accept, out_chan.occupancy == OCC_W'(count_r), "bad occupancy")
  `SPQ_ASSERT_NEXT(a_empty_status, rm_empty, status_r == ST_EMPTY && empty, "empty removal")
  `SPQ_ASSERT_NEXT(a_full_hold, ins_full, status_r == ST_FULL && $stable(count_r), "full insert")

endmodule

`default_nettype wire
